[hdl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg - shared types and constants for the symbol frequency ranker
// Table size, count width, cell operation codes and the ranking compare.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int MAX_DISTINCT = 64;
  localparam int COUNT_BITS   = 16;
  localparam int SYM_W        = 8;
  localparam int OCC_W        = 16;
  localparam int USED_W       = $clog2(MAX_DISTINCT + 1);

  // one table entry as held by a cell
  typedef struct packed {
    logic [SYM_W-1:0]      sym;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  // what the row of cells does this cycle
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_COUNT = 2'd1,
    OP_SORT  = 2'd2,
    OP_SHIFT = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic parity;  // which pairs compare in this sort phase
  } ctrl_t;

  // true if entry a ranks ahead of entry b: higher count, then lower symbol
  function automatic logic ranks_before(input entry_t a, input entry_t b);
    if (a.cnt != b.cnt) begin
      return a.cnt > b.cnt;
    end
    return a.sym < b.sym;
  endfunction

  // reported count, low OCC_W bits of the stored count
  function automatic logic [OCC_W-1:0] to_occ(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/sfr_cell.sv]
// ---------------------------------------------------------------------------
// sfr_cell - one table entry of the ranker row
// Matches and counts the broadcast symbol, takes part in odd-even
// transposition sorting with its neighbours, and shifts left on readout.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_cell
  import sfr_pkg::*;
(
  input  wire logic             clk,
  input  wire ctrl_t            ctl,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             in_use,    // entry holds a live symbol
  input  wire logic             take_new,  // first free entry
  input  wire logic             lead_en,   // this cell leads an active pair
  input  wire entry_t           left_ent,
  input  wire logic             left_swap,
  input  wire entry_t           right_ent,
  output entry_t                ent,
  output logic                  swap,
  output logic                  hit
);

  entry_t ent_next;

  logic [COUNT_BITS-1:0] cnt_top;
  assign cnt_top = '1;

  // match against the incoming symbol
  assign hit  = in_use && (ent.sym == symbol);

  // swap with the right neighbour when it ranks ahead
  assign swap = lead_en && ranks_before(right_ent, ent);

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      OP_HOLD: begin
        ent_next = ent;
      end
      OP_COUNT: begin
        if (hit) begin
          if (ent.cnt != cnt_top) begin
            ent_next.cnt = ent.cnt + 1'b1;
          end
        end else if (take_new) begin
          ent_next.sym = symbol;
          ent_next.cnt = COUNT_BITS'(1);
        end
      end
      OP_SORT: begin
        if (swap) begin
          ent_next = right_ent;
        end else if (left_swap) begin
          ent_next = left_ent;
        end
      end
      OP_SHIFT: begin
        ent_next = right_ent;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

[hdl/sfr_ctrl.sv]
// ---------------------------------------------------------------------------
// sfr_ctrl - sequencer for the ranker
// Tracks the fill count and overflow flag, runs the sort phases after the
// final item and then strobes the ranked items out of the head cell.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              final_item,
  input  wire logic              any_hit,
  output logic                   busy,
  output ctrl_t                  ctl,
  output logic [USED_W-1:0]      used,
  output logic                   overflowed,
  output logic                   strobe,
  output logic                   run_end
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [USED_W-1:0]  used_next;
  logic               overflowed_next;
  logic [USED_W-1:0]  remaining, remaining_next;
  logic               parity, parity_next;
  logic               accept;

  assign accept  = start && (state == ST_IDLE);
  assign busy    = (state != ST_IDLE);
  assign strobe  = (state == ST_EMIT);
  assign run_end = strobe && (remaining == USED_W'(1));

  // next state and counters
  always_comb begin
    state_next      = state;
    used_next       = used;
    overflowed_next = overflowed;
    remaining_next  = remaining;
    parity_next     = parity;
    ctl.op          = OP_HOLD;
    ctl.parity      = parity;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.op = OP_COUNT;
          if (!any_hit) begin
            if (used == USED_W'(MAX_DISTINCT)) begin
              overflowed_next = 1'b1;
            end else begin
              used_next = used + 1'b1;
            end
          end
          if (final_item) begin
            state_next     = ST_SORT;
            remaining_next = used_next;
            parity_next    = 1'b0;
          end
        end
      end
      ST_SORT: begin
        ctl.op      = OP_SORT;
        parity_next = ~parity;
        if (remaining == USED_W'(1)) begin
          state_next     = ST_EMIT;
          remaining_next = used;
        end else begin
          remaining_next = remaining - 1'b1;
        end
      end
      ST_EMIT: begin
        ctl.op = OP_SHIFT;
        if (remaining == USED_W'(1)) begin
          state_next      = ST_IDLE;
          used_next       = '0;
          overflowed_next = 1'b0;
        end else begin
          remaining_next = remaining - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      overflowed <= 1'b0;
      remaining  <= '0;
      parity     <= 1'b0;
    end else begin
      state      <= state_next;
      used       <= used_next;
      overflowed <= overflowed_next;
      remaining  <= remaining_next;
      parity     <= parity_next;
    end
  end

  // fill count never passes the table size
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(MAX_DISTINCT))
    else $error("fill count beyond table size");

  // a readout never runs on an empty table
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (used != '0) && (remaining != '0))
    else $error("readout with no entries");

  // last item of a run returns the block to idle with fill count and overflow flag cleared
  a_run_end_idle: assert property (@(posedge clk) disable iff (rst)
    run_end |=> !busy && (used == '0) && !overflowed)
    else $error("table not cleared after last item");

  // a final item always leads to sorting
  a_final_sorts: assert property (@(posedge clk) disable iff (rst)
    (accept && final_item) |=> (state == ST_SORT))
    else $error("final item did not start sort");

endmodule

`default_nettype wire

[hdl/symbol_frequency_rank.sv]
// ---------------------------------------------------------------------------
// symbol_frequency_rank - byte histogram ranked by frequency
// A row of MAX_DISTINCT cells counts symbols by parallel match, then sorts
// itself by odd-even transposition and shifts the ranked entries out.
// ---------------------------------------------------------------------------
// Counting: one item per cycle; busy stays low for items not marked final.
// After a final item with n distinct symbols in the table: the sort phases,
// then the n results one per cycle; busy stays high through both.
// The first result is on the ports as soon as the last sort phase is done.
// Reset clears the fill count, overflow flag and sequencer; entries need none.
`default_nettype none

module symbol_frequency_rank
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic              final_item,
  output logic                   strobe,
  output logic [SYM_W-1:0]       ranked_symbol,
  output logic [OCC_W-1:0]       occurrences,
  output logic                   overflowed,
  output logic                   run_end
);

  ctrl_t                    ctl;
  logic [USED_W-1:0]        used;
  entry_t                   ents  [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0]  swaps;
  logic [MAX_DISTINCT-1:0]  hits;
  logic                     any_hit;

  assign any_hit = |hits;

  sfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .final_item (final_item),
    .any_hit    (any_hit),
    .busy       (busy),
    .ctl        (ctl),
    .used       (used),
    .overflowed (overflowed),
    .strobe     (strobe),
    .run_end    (run_end)
  );

  // row of cells, entry 0 at the head
  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    logic   in_use, take_new, lead_en, left_swap;
    entry_t left_ent, right_ent;

    assign in_use   = used > USED_W'(i);
    assign take_new = used == USED_W'(i);
    assign lead_en  = (ctl.parity == 1'(i % 2)) && (USED_W'(i + 1) < used);

    if (i == 0) begin : g_head
      assign left_ent  = ents[i];
      assign left_swap = 1'b0;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign left_swap = swaps[i-1];
    end

    if (i == MAX_DISTINCT - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    sfr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .symbol    (symbol),
      .in_use    (in_use),
      .take_new  (take_new),
      .lead_en   (lead_en),
      .left_ent  (left_ent),
      .left_swap (left_swap),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .swap      (swaps[i]),
      .hit       (hits[i])
    );
  end

  // results come from the head cell
  assign ranked_symbol = ents[0].sym;
  assign occurrences   = to_occ(ents[0].cnt);

endmodule

`default_nettype wire

[sim/symbol_frequency_rank_test.sv]
// ---------------------------------------------------------------------------
// symbol_frequency_rank_test - self-checking bench for the frequency ranker
// Sends data sets of byte symbols, with a local histogram that predicts the
// ranked readout of each set. Every strobed result is compared field by
// field, in order, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module symbol_frequency_rank_test
  import sfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 230;
  localparam int QUIET_FROM   = 190;    // no sender idling past this item

  // one ranked result as the block should present it
  typedef struct {
    logic [SYM_W-1:0] sym;
    logic [OCC_W-1:0] occ;
    logic             ovf;
    logic             last;
  } ranked_t;

  // histogram of the current data set and the readouts still to arrive
  class freq_rank_board;
    logic [SYM_W-1:0]      sym_tab [MAX_DISTINCT];
    logic [COUNT_BITS-1:0] cnt_tab [MAX_DISTINCT];
    int                    fill;
    bit                    dropped;
    ranked_t               ranked_due[$];
    int                    errors;

    function new();
      fill    = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function int pending();
      return ranked_due.size();
    endfunction

    // count one accepted item; a final item queues the ranked readout
    function void note_symbol(logic [SYM_W-1:0] sym, logic fin);
      int      hit;
      int      idx [MAX_DISTINCT];
      int      tmp;
      int      j;
      bit      ahead;
      ranked_t r;
      hit = -1;
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && sym_tab[i] == sym) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        if (cnt_tab[hit] != {COUNT_BITS{1'b1}}) begin
          cnt_tab[hit] = cnt_tab[hit] + 1'b1;
        end
      end else if (fill < MAX_DISTINCT) begin
        sym_tab[fill] = sym;
        cnt_tab[fill] = 1;
        fill++;
      end else begin
        dropped = 1;
      end
      if (!fin) begin
        return;
      end
      // insertion sort: higher count first, then lower symbol
      for (int i = 0; i < fill; i++) begin
        idx[i] = i;
      end
      for (int i = 1; i < fill; i++) begin
        tmp = idx[i];
        j   = i - 1;
        while (j >= 0) begin
          ahead = (cnt_tab[tmp] > cnt_tab[idx[j]]) ||
                  (cnt_tab[tmp] == cnt_tab[idx[j]] && sym_tab[tmp] < sym_tab[idx[j]]);
          if (!ahead) begin
            break;
          end
          idx[j + 1] = idx[j];
          j--;
        end
        idx[j + 1] = tmp;
      end
      for (int i = 0; i < fill; i++) begin
        r.sym  = sym_tab[idx[i]];
        r.occ  = cnt_tab[idx[i]][OCC_W-1:0];
        r.ovf  = dropped;
        r.last = (i == fill - 1);
        ranked_due = {ranked_due, r};
      end
      fill    = 0;
      dropped = 0;
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_ranked(logic [SYM_W-1:0] sym, logic [OCC_W-1:0] occ,
                               logic ovf, logic last);
      ranked_t r;
      if (ranked_due.size() == 0) begin
        $display("%0t: unexpected result: symbol %02h count %0d", $time, sym, occ);
        errors++;
        return;
      end
      r = ranked_due.pop_front();
      if (sym !== r.sym) begin
        $display("%0t: ranked_symbol expected %02h got %02h", $time, r.sym, sym);
        errors++;
      end
      if (occ !== r.occ) begin
        $display("%0t: occurrences expected %0d got %0d", $time, r.occ, occ);
        errors++;
      end
      if (ovf !== r.ovf) begin
        $display("%0t: overflowed expected %b got %b", $time, r.ovf, ovf);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: run_end expected %b got %b", $time, r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [SYM_W-1:0] symbol;
  logic             final_item;
  logic             strobe;
  logic [SYM_W-1:0] ranked_symbol;
  logic [OCC_W-1:0] occurrences;
  logic             overflowed;
  logic             run_end;

  freq_rank_board board;
  int             cycles;

  symbol_frequency_rank u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .symbol        (symbol),
    .final_item    (final_item),
    .strobe        (strobe),
    .ranked_symbol (ranked_symbol),
    .occurrences   (occurrences),
    .overflowed    (overflowed),
    .run_end       (run_end)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** symbol_frequency_rank: FAILED **");
      $finish;
    end
  end

  // monitor: note accepted items, then check strobed results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_symbol(symbol, final_item);
      end
      if (strobe) begin
        board.check_ranked(ranked_symbol, occurrences, overflowed, run_end);
      end
    end
  end

  // present one item from the falling edge and hold it until accepted
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic fin);
    @(negedge clk);
    start      = 1'b1;
    symbol     = sym;
    final_item = fin;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // sender idles with start low, with noise on the payload
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start      = 1'b0;
      symbol     = SYM_W'($urandom);
      final_item = 1'($urandom);
    end
  endtask

  // hold off until every queued readout has come out
  task automatic drain_readouts();
    @(negedge clk);
    start = 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int               sent;
    int               kind;
    int               len;
    int               alpha_n;
    bit               gaps_on;
    logic [SYM_W-1:0] alpha [8];
    logic [SYM_W-1:0] sym;

    board      = new();
    cycles     = 0;
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    symbol     = '0;
    final_item = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-item sets at both symbol extremes
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    // ties broken by symbol; final item repeats a symbol already counted
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b1);
    // new set straight after another set's final item, sender held off during readout
    send_item(8'h55, 1'b0);
    idle_sender(2);
    send_item(8'hAA, 1'b1);
    drain_readouts();

    // table filled exactly by the final item: 64 results, no drop
    for (int i = 0; i < MAX_DISTINCT - 1; i++) begin
      send_item(SYM_W'(i * 4 + 3), 1'b0);
    end
    send_item(8'hFF, 1'b1);

    // table overflow: new symbols dropped, final one too, flag then clears
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      send_item(SYM_W'(i * 4), 1'b0);
    end
    for (int i = 0; i < 6; i++) begin
      send_item(SYM_W'(i * 2 + 1), 1'b0);
    end
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h42, 1'b1);
    drain_readouts();

    // random data sets: mostly small alphabets to force ties
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 99);
      gaps_on = $urandom_range(0, 1);
      alpha_n = $urandom_range(1, 8);
      for (int i = 0; i < 8; i++) begin
        alpha[i] = SYM_W'($urandom);
      end
      if (kind < 60) begin
        len = $urandom_range(1, 24);
      end else if (kind < 90) begin
        len = $urandom_range(1, 40);
      end else begin
        len = $urandom_range(66, 90);
      end
      for (int k = 0; k < len; k++) begin
        if (kind < 60) begin
          sym = alpha[$urandom_range(0, alpha_n - 1)];
        end else begin
          sym = SYM_W'($urandom_range(0, 255));
        end
        if (gaps_on && sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
          idle_sender($urandom_range(1, 4));
        end
        send_item(sym, k == len - 1);
        sent++;
      end
    end

    // wind down: wait for the last readout, then watch for strays
    drain_readouts();
    repeat (2 * MAX_DISTINCT + 8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** symbol_frequency_rank: PASSED **");
    end else begin
      $display("** symbol_frequency_rank: FAILED **");
    end
    $finish;
  end

endmodule
